// File: design/fcc_pkg.sv
package fcc_pkg;

   // Field widths fixed by the transaction format
   localparam int BYTE_W = 8;
   localparam int POS_W  = 8;
   localparam int CRC_W  = 32;

   // Default longest stored name
   localparam int NAME_MAX_DEF = 255;

   // Reflected CRC-32
   localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   // Most result bytes one transaction can produce
   localparam int JOB_BYTES = 3;
   localparam int JOB_CNT_W = 2;

   // Byte job handed from the decoder to the emitter
   typedef struct packed {
      logic                                load;
      logic                                clr;
      logic [JOB_CNT_W-1:0]                cnt;
      logic [JOB_BYTES-1:0][BYTE_W-1:0]    bytes;
   } fcc_job_type;

endpackage

// File: design/front_coding_encoder_crc32_core.sv
// Front-coding encoder with running CRC-32. Each transaction is one name character or a
// start command. When the shared prefix with the previous name ends, the block returns the
// prefix length, the suffix length and then the suffix characters; an empty name returns
// two zero bytes. Every result carries the finalized reflected CRC-32 over all bytes
// returned since the last start, and last marks the final result of a transaction. The
// previous name lives in a single-port read-first RAM, read at acceptance, with its
// registered byte compared in the decode stage. A transaction returns one to three result
// bytes, or none; the output emitter runs one byte and one CRC update a cycle while its
// output is not stalled. The first result passes the front stage, the emitter's job
// register and its output register before it is offered.
module front_coding_encoder_crc32_core
   import fcc_pkg::*;
#(
   parameter int NAME_MAX = NAME_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [BYTE_W-1:0] req_ch,
   input  logic [POS_W-1:0]  req_name_length,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic [CRC_W-1:0]  rsp_crc_value,
   output logic              rsp_last
);

   localparam int               AW       = $clog2(NAME_MAX);
   localparam logic [POS_W:0]   NameMaxW = (POS_W+1)'(NAME_MAX);

   logic              accept;
   logic              job_free;
   logic              s1_adv;
   fcc_job_type       job;

   // Front stage: position counter and RAM access
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W:0]    acc_next;
   logic              acc_end;
   logic              mem_wr;
   logic [BYTE_W-1:0] name_rd;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_cmd_ff;
   logic [BYTE_W-1:0] s1_ch_ff;
   logic [POS_W-1:0]  s1_nl_ff;
   logic [POS_W-1:0]  s1_pos_ff;
   logic              s1_end_ff;

   assign accept   = req_valid && !req_stall;
   assign acc_next = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign acc_end  = acc_next >= {1'b0, req_name_length};
   assign mem_wr   = accept && !req_cmd && (req_name_length != '0) &&
                     ({1'b0, pos_ff} < NameMaxW);

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_cmd || (req_name_length == '0) || acc_end) begin
            pos_in = '0;
         end else begin
            pos_in = acc_next[POS_W-1:0];
         end
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_cmd_ff <= req_cmd;
         s1_ch_ff  <= req_ch;
         s1_nl_ff  <= req_name_length;
         s1_pos_ff <= pos_ff;
         s1_end_ff <= acc_end;
      end
   end

   fcc_name_mem #(
      .NAME_MAX (NAME_MAX),
      .AW       (AW)
   ) u_name_mem (
      .clock   (clock),
      .rd_en   (accept),
      .wr_en   (mem_wr),
      .addr    (pos_ff[AW-1:0]),
      .wr_data (req_ch),
      .rd_data (name_rd)
   );

   // Decode stage: compare with the previous name, build the byte job
   logic [POS_W-1:0]  prev_len_ff, prev_len_in;
   logic [POS_W-1:0]  match_ff, match_in;
   logic              still_ff, still_in;

   logic [POS_W-1:0]                 dec_prev_len;
   logic [POS_W-1:0]                 dec_match;
   logic                             dec_still;
   logic [JOB_CNT_W-1:0]             dec_cnt;
   logic [JOB_BYTES-1:0][BYTE_W-1:0] dec_bytes;
   logic [POS_W:0]                   s1_next;
   logic                             matched;

   assign s1_adv  = s1_valid_ff && job_free;
   assign s1_next = {1'b0, s1_pos_ff} + (POS_W+1)'(1);
   assign matched = still_ff && (s1_pos_ff < prev_len_ff) &&
                    ({1'b0, s1_pos_ff} < NameMaxW) && (name_rd == s1_ch_ff);

   always_comb begin
      dec_prev_len = prev_len_ff;
      dec_match    = match_ff;
      dec_still    = still_ff;
      dec_cnt      = '0;
      dec_bytes    = '0;
      if (s1_cmd_ff) begin
         dec_prev_len = '0;
         dec_match    = '0;
         dec_still    = 1'b1;
      end else if (s1_nl_ff == '0) begin
         // empty name
         dec_cnt      = JOB_CNT_W'(2);
         dec_prev_len = '0;
         dec_match    = '0;
         dec_still    = 1'b1;
      end else begin
         if (matched) begin
            dec_match = s1_next[POS_W-1:0];
            if (s1_end_ff) begin
               dec_bytes[0] = s1_next[POS_W-1:0];
               dec_cnt      = JOB_CNT_W'(2);
            end
         end else if (still_ff) begin
            dec_bytes[0] = match_ff;
            dec_bytes[1] = s1_nl_ff - match_ff;
            dec_bytes[2] = s1_ch_ff;
            dec_cnt      = JOB_CNT_W'(3);
            dec_still    = 1'b0;
         end else begin
            dec_bytes[0] = s1_ch_ff;
            dec_cnt      = JOB_CNT_W'(1);
         end
         if (s1_end_ff) begin
            dec_prev_len = (s1_next > NameMaxW) ? NameMaxW[POS_W-1:0]
                                                : s1_next[POS_W-1:0];
            dec_match    = '0;
            dec_still    = 1'b1;
         end
      end
   end

   assign prev_len_in = s1_adv ? dec_prev_len : prev_len_ff;
   assign match_in    = s1_adv ? dec_match    : match_ff;
   assign still_in    = s1_adv ? dec_still    : still_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_len_ff <= '0;
         match_ff    <= '0;
         still_ff    <= 1'b1;
      end else begin
         prev_len_ff <= prev_len_in;
         match_ff    <= match_in;
         still_ff    <= still_in;
      end
   end

   always_comb begin
      job.load  = s1_adv && (dec_cnt != '0);
      job.clr   = s1_adv && s1_cmd_ff;
      job.cnt   = dec_cnt;
      job.bytes = dec_bytes;
   end

   // The front stage holds while the emitter cannot take its job
   assign req_stall = s1_valid_ff && !job_free;

   fcc_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .job           (job),
      .job_free      (job_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_crc_value (rsp_crc_value),
      .rsp_last      (rsp_last)
   );

endmodule

// File: design/fcc_name_mem.sv
module fcc_name_mem
   import fcc_pkg::*;
#(
   parameter int NAME_MAX = NAME_MAX_DEF,
   parameter int AW       = $clog2(NAME_MAX)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic              wr_en,
   input  logic [AW-1:0]     addr,
   input  logic [BYTE_W-1:0] wr_data,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [NAME_MAX];
   logic [BYTE_W-1:0] rd_data_ff;

   // Read-first port: a read and a write at the same address return the old byte
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/fcc_emit.sv
module fcc_emit
   import fcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  fcc_job_type       job,
   output logic              job_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic [CRC_W-1:0]  rsp_crc_value,
   output logic              rsp_last
);

   // One byte through the reflected CRC, eight bit steps
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int i = 0; i < BYTE_W; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

   logic                             job_valid_ff, job_valid_in;
   logic [JOB_CNT_W-1:0]             cnt_ff, cnt_in;
   logic [JOB_CNT_W-1:0]             idx_ff, idx_in;
   logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes_ff, bytes_in;
   logic [CRC_W-1:0]                 crc_ff, crc_in;
   logic                             out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]                out_byte_ff, out_byte_in;
   logic [CRC_W-1:0]                 out_crc_ff, out_crc_in;
   logic                             out_last_ff, out_last_in;

   logic              take;
   logic              finishing;
   logic [BYTE_W-1:0] cur_byte;
   logic [CRC_W-1:0]  crc_upd;

   // Move one byte into the output register when it is empty or being drained
   assign take      = job_valid_ff && (!out_valid_ff || !rsp_stall);
   assign cur_byte  = bytes_ff[idx_ff];
   assign crc_upd   = crc_byte(crc_ff, cur_byte);
   assign finishing = take && (idx_ff == cnt_ff - JOB_CNT_W'(1));
   assign job_free  = !job_valid_ff || finishing;

   // Job sequencing
   always_comb begin
      job_valid_in = job_valid_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      bytes_in     = bytes_ff;
      if (job.load && job_free) begin
         job_valid_in = 1'b1;
         cnt_in       = job.cnt;
         idx_in       = '0;
         bytes_in     = job.bytes;
      end else if (finishing) begin
         job_valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + JOB_CNT_W'(1);
      end
   end

   // Running CRC; a start transaction restarts it after the last byte before it
   always_comb begin
      if (job.clr) begin
         crc_in = CRC_ALL_ONES;
      end else if (take) begin
         crc_in = crc_upd;
      end else begin
         crc_in = crc_ff;
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_crc_in   = out_crc_ff;
      out_last_in  = out_last_ff;
      if (take) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_crc_in   = crc_upd ^ CRC_ALL_ONES;
         out_last_in  = finishing;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         crc_ff       <= CRC_ALL_ONES;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
      bytes_ff    <= bytes_in;
      out_byte_ff <= out_byte_in;
      out_crc_ff  <= out_crc_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_crc_value = out_crc_ff;
   assign rsp_last      = out_last_ff;

endmodule

// File: design/fcc_checker.sv
module fcc_checker
   import fcc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic [CRC_W-1:0]  rsp_crc_value,
   input logic              rsp_last
);

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // The input side only starts stalling after taking a transaction
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("input stall rose without a preceding transaction");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result withdrawn");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_byte) && $stable(rsp_crc_value) &&
                                 $stable(rsp_last))
      else $error("stalled result payload changed");

endmodule

bind front_coding_encoder_crc32_core fcc_checker u_fcc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_crc_value (rsp_crc_value),
   .rsp_last      (rsp_last)
);
